### src/nsd_pkg.sv
// Shared types, codes and decode tables of the NMEA sentence decoder.
package nsd_pkg;

    typedef enum logic [2:0] {
        KIND_GGA  = 3'd0,
        KIND_GSA  = 3'd1,
        KIND_RMC  = 3'd2,
        KIND_GSV  = 3'd3,
        KIND_NONE = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        QID_TIME       = 5'd0,
        QID_DATE       = 5'd1,
        QID_LAT        = 5'd2,
        QID_LON        = 5'd3,
        QID_ALT        = 5'd4,
        QID_SPEED      = 5'd5,
        QID_COURSE     = 5'd6,
        QID_HDOP       = 5'd7,
        QID_PDOP       = 5'd8,
        QID_VDOP       = 5'd9,
        QID_FIXQ       = 5'd10,
        QID_FIXTYPE    = 5'd11,
        QID_SATS       = 5'd12,
        QID_VISIBLE    = 5'd13,
        QID_SNR_AVG    = 5'd14,
        QID_TIME_STAMP = 5'd15,
        QID_POS_STAMP  = 5'd16
    } qid_t;

    // what a completed term updates
    typedef enum logic [4:0] {
        ACT_NONE, ACT_TYPE, ACT_TIME, ACT_LAT, ACT_LAT_SIGN, ACT_LON, ACT_LON_SIGN,
        ACT_FIXQ, ACT_SATS, ACT_HDOP, ACT_ALT, ACT_FIXTYPE, ACT_PDOP, ACT_VDOP,
        ACT_STATUS, ACT_SPEED, ACT_COURSE, ACT_DATE, ACT_GTOT, ACT_GIDX, ACT_VIS,
        ACT_SNR
    } act_t;

    typedef enum logic [1:0] {
        CLS_IMM, CLS_DEC, CLS_DEG, CLS_CNT
    } cls_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_IMM, OP_DEC_START, OP_DEC_INT, OP_DEC_DOT, OP_DEC_F1, OP_DEC_F2,
        OP_DEG_START, OP_DEG_LOOK, OP_DEG_INT, OP_DEG_SCALE, OP_DEG_M1, OP_DEG_M2,
        OP_DEG_MLOOP, OP_DEG_MUL, OP_DEG_FIN, OP_CNT_START, OP_CNT_STEP, OP_COMMIT,
        OP_TERM_END, OP_TAIL, OP_DIV_START, OP_DIV_STEP, OP_EMIT, OP_GSV_CLEAR
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_DEC_INT, S_DEC_DOT, S_DEC_F1, S_DEC_F2, S_DEG_LOOK,
        S_DEG_INT, S_DEG_SCALE, S_DEG_M1, S_DEG_M2, S_DEG_MLOOP, S_DEG_MUL,
        S_DEG_FIN, S_CNT, S_COMMIT, S_TERM_END, S_TAIL, S_DIV_START, S_DIV,
        S_EMIT, S_CLEAR
    } ctrl_state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_delim;
        cls_t cls;
        logic digit;
        logic dot;
        logic deg_go;
        logic cnt_more;
        logic star_match;
        logic sent_valid;
        logic is_gsv;
        logic div_done;
        logic out_free;
        logic emit_last;
    } dp_stat_t;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam logic [39:0] TAG_GGA = 40'h4750474741;
    localparam logic [39:0] TAG_GSA = 40'h4750475341;
    localparam logic [39:0] TAG_RMC = 40'h4750524D43;
    localparam logic [39:0] TAG_GSV = 40'h4750475356;

    localparam logic [31:0] INV_TIME  = 32'hFFFF_FFFF;
    localparam logic [31:0] INV_ANGLE = 32'd999999999;
    localparam logic [15:0] INV_DOP   = 16'hFFFF;
    localparam logic [7:0]  INV_SATS  = 8'hFF;
    localparam logic [31:0] RECIP_SIX = 32'hAAAA_AAAB;
    localparam int          DIV_STEPS = 23;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
        else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
        else if (is_digit(b)) v = b - CH_ZERO;
        return v[3:0];
    endfunction

    function automatic act_t classify(input kind_t t, input logic [7:0] k);
        act_t a;
        a = ACT_NONE;
        if (k == 8'd0) begin
            a = ACT_TYPE;
        end else begin
            unique case (t)
                KIND_GGA: begin
                    case (k)
                        8'd1: a = ACT_TIME;
                        8'd2: a = ACT_LAT;
                        8'd3: a = ACT_LAT_SIGN;
                        8'd4: a = ACT_LON;
                        8'd5: a = ACT_LON_SIGN;
                        8'd6: a = ACT_FIXQ;
                        8'd7: a = ACT_SATS;
                        8'd8: a = ACT_HDOP;
                        8'd9: a = ACT_ALT;
                        default: a = ACT_NONE;
                    endcase
                end
                KIND_RMC: begin
                    case (k)
                        8'd1: a = ACT_TIME;
                        8'd2: a = ACT_STATUS;
                        8'd3: a = ACT_LAT;
                        8'd4: a = ACT_LAT_SIGN;
                        8'd5: a = ACT_LON;
                        8'd6: a = ACT_LON_SIGN;
                        8'd7: a = ACT_SPEED;
                        8'd8: a = ACT_COURSE;
                        8'd9: a = ACT_DATE;
                        default: a = ACT_NONE;
                    endcase
                end
                KIND_GSA: begin
                    case (k)
                        8'd2:  a = ACT_FIXTYPE;
                        8'd15: a = ACT_PDOP;
                        8'd16: a = ACT_HDOP;
                        8'd17: a = ACT_VDOP;
                        default: a = ACT_NONE;
                    endcase
                end
                KIND_GSV: begin
                    case (k)
                        8'd1: a = ACT_GTOT;
                        8'd2: a = ACT_GIDX;
                        8'd3: a = ACT_VIS;
                        8'd7, 8'd11, 8'd15, 8'd19: a = ACT_SNR;
                        default: a = ACT_NONE;
                    endcase
                end
                default: a = ACT_NONE;
            endcase
        end
        return a;
    endfunction

    function automatic cls_t act_cls(input act_t a);
        cls_t c;
        unique case (a)
            ACT_TIME, ACT_HDOP, ACT_ALT, ACT_PDOP, ACT_VDOP, ACT_SPEED, ACT_COURSE,
            ACT_DATE: c = CLS_DEC;
            ACT_LAT, ACT_LON: c = CLS_DEG;
            ACT_SATS, ACT_GTOT, ACT_GIDX, ACT_VIS, ACT_SNR: c = CLS_CNT;
            default: c = CLS_IMM;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] run_len(input kind_t t);
        logic [3:0] n;
        unique case (t)
            KIND_GGA: n = 4'd9;
            KIND_GSA: n = 4'd4;
            KIND_RMC: n = 4'd8;
            KIND_GSV: n = 4'd2;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic qid_t emit_id(input kind_t t, input logic [3:0] slot);
        qid_t q;
        q = QID_TIME;
        unique case (t)
            KIND_GGA: begin
                case (slot)
                    4'd0: q = QID_TIME;
                    4'd1: q = QID_LAT;
                    4'd2: q = QID_LON;
                    4'd3: q = QID_ALT;
                    4'd4: q = QID_HDOP;
                    4'd5: q = QID_FIXQ;
                    4'd6: q = QID_SATS;
                    4'd7: q = QID_TIME_STAMP;
                    default: q = QID_POS_STAMP;
                endcase
            end
            KIND_GSA: begin
                case (slot)
                    4'd0: q = QID_HDOP;
                    4'd1: q = QID_PDOP;
                    4'd2: q = QID_VDOP;
                    default: q = QID_FIXTYPE;
                endcase
            end
            KIND_RMC: begin
                case (slot)
                    4'd0: q = QID_TIME;
                    4'd1: q = QID_DATE;
                    4'd2: q = QID_LAT;
                    4'd3: q = QID_LON;
                    4'd4: q = QID_SPEED;
                    4'd5: q = QID_COURSE;
                    4'd6: q = QID_TIME_STAMP;
                    default: q = QID_POS_STAMP;
                endcase
            end
            KIND_GSV: q = (slot == 4'd0) ? QID_VISIBLE : QID_SNR_AVG;
            default: q = QID_TIME;
        endcase
        return q;
    endfunction

endpackage

### src/nsd_ctrl.sv
// Sequencer: steps the datapath through term parsing, checksum and result runs.
module nsd_ctrl
    import nsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_acc,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     s_ready
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_acc && stat.is_delim) state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (stat.cls)
                    CLS_DEC: state_next = S_DEC_INT;
                    CLS_DEG: state_next = S_DEG_LOOK;
                    CLS_CNT: state_next = S_CNT;
                    default: state_next = S_TERM_END;
                endcase
            end
            S_DEC_INT:   if (!stat.digit) state_next = S_DEC_DOT;
            S_DEC_DOT:   state_next = stat.dot ? S_DEC_F1 : S_COMMIT;
            S_DEC_F1:    state_next = stat.digit ? S_DEC_F2 : S_COMMIT;
            S_DEC_F2:    state_next = S_COMMIT;
            S_DEG_LOOK:  state_next = S_DEG_INT;
            S_DEG_INT:   state_next = stat.deg_go ? S_DEG_LOOK : S_DEG_SCALE;
            S_DEG_SCALE: state_next = S_DEG_M1;
            S_DEG_M1:    state_next = S_DEG_M2;
            S_DEG_M2:    state_next = S_DEG_MLOOP;
            S_DEG_MLOOP: if (!stat.digit) state_next = S_DEG_MUL;
            S_DEG_MUL:   state_next = S_DEG_FIN;
            S_DEG_FIN:   state_next = S_COMMIT;
            S_CNT:       if (!stat.cnt_more) state_next = S_COMMIT;
            S_COMMIT:    state_next = S_TERM_END;
            S_TERM_END: begin
                if (!stat.star_match)     state_next = S_TAIL;
                else if (!stat.sent_valid) state_next = S_IDLE;
                else if (stat.is_gsv)      state_next = S_DIV_START;
                else                       state_next = S_EMIT;
            end
            S_TAIL:      state_next = S_IDLE;
            S_DIV_START: state_next = S_DIV;
            S_DIV:       if (stat.div_done) state_next = S_EMIT;
            S_EMIT: begin
                if (stat.out_free && stat.emit_last)
                    state_next = stat.is_gsv ? S_CLEAR : S_IDLE;
            end
            S_CLEAR:     state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NOP;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:      s_ready = 1'b1;
            S_DISPATCH: begin
                unique case (stat.cls)
                    CLS_DEC: cmd.op = OP_DEC_START;
                    CLS_DEG: cmd.op = OP_DEG_START;
                    CLS_CNT: cmd.op = OP_CNT_START;
                    default: cmd.op = OP_IMM;
                endcase
            end
            S_DEC_INT:   cmd.op = OP_DEC_INT;
            S_DEC_DOT:   cmd.op = OP_DEC_DOT;
            S_DEC_F1:    cmd.op = OP_DEC_F1;
            S_DEC_F2:    cmd.op = OP_DEC_F2;
            S_DEG_LOOK:  cmd.op = OP_DEG_LOOK;
            S_DEG_INT:   cmd.op = OP_DEG_INT;
            S_DEG_SCALE: cmd.op = OP_DEG_SCALE;
            S_DEG_M1:    cmd.op = OP_DEG_M1;
            S_DEG_M2:    cmd.op = OP_DEG_M2;
            S_DEG_MLOOP: cmd.op = OP_DEG_MLOOP;
            S_DEG_MUL:   cmd.op = OP_DEG_MUL;
            S_DEG_FIN:   cmd.op = OP_DEG_FIN;
            S_CNT:       cmd.op = stat.cnt_more ? OP_CNT_STEP : OP_NOP;
            S_COMMIT:    cmd.op = OP_COMMIT;
            S_TERM_END:  cmd.op = OP_TERM_END;
            S_TAIL:      cmd.op = OP_TAIL;
            S_DIV_START: cmd.op = OP_DIV_START;
            S_DIV:       cmd.op = stat.div_done ? OP_NOP : OP_DIV_STEP;
            S_EMIT:      cmd.op = OP_EMIT;
            S_CLEAR:     cmd.op = OP_GSV_CLEAR;
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule

### src/nsd_datapath.sv
// Term buffer, parsers, pending quantities, SNR divider and result register.
module nsd_datapath
    import nsd_pkg::*;
#(
    parameter int TERM_SIZE = 16
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_acc,
    input  logic [7:0]         s_char_in,
    input  logic [31:0]        s_now_ms,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [1:0]         m_sentence_kind,
    output logic [4:0]         m_quantity_id,
    output logic signed [32:0] m_quantity_value,
    output logic               m_last_of_run
);

    localparam int AW = $clog2(TERM_SIZE);
    localparam int IW = AW + 2;

    logic [7:0]    buf_reg [TERM_SIZE];
    logic [7:0]    head_reg [5];
    logic [AW-1:0] len_reg;
    logic [7:0]    k_reg;
    kind_t         type_reg;
    logic [7:0]    parity_reg;
    logic          inchk_reg;
    logic          status_reg;
    logic [31:0]   time_reg, date_reg, lat_reg, lon_reg, alt_reg, speed_reg, course_reg;
    logic [15:0]   hdop_reg, pdop_reg, vdop_reg;
    logic [3:0]    fixq_reg, fixtype_reg;
    logic [7:0]    sats_reg, vis_reg, gtot_reg, gidx_reg;
    logic [15:0]   snr_reg;
    logic [31:0]   tstamp_reg, pstamp_reg;

    logic [7:0]    char_reg;
    logic [31:0]   now_reg;
    act_t          act_reg;
    logic          star_reg;
    logic [IW-1:0] i_reg;
    logic          neg_reg;
    logic          look_dot_reg;
    logic [31:0]   acc_reg, mn_reg;
    logic [63:0]   prod_reg;
    logic [22:0]   dvd_reg;
    logic [7:0]    rem_reg;
    logic [4:0]    dcnt_reg;
    logic [3:0]    slot_reg;

    logic          m_valid_reg, m_last_reg;
    logic [1:0]    m_kind_reg;
    logic [4:0]    m_id_reg;
    logic [32:0]   m_value_reg;

    logic [IW-1:0] rd_idx;
    logic [7:0]    rd_byte, hb0, hb1, hb2;
    logic [31:0]   dig, byte_off, res, abs_mn, q32;
    logic          is_delim, out_free, emit_load;
    logic [7:0]    chk;
    logic [8:0]    trial;
    logic          qbit;
    qid_t          eid;
    logic [32:0]   evalue;

    assign rd_idx  = (cmd.op == OP_DEG_LOOK) ? i_reg + IW'(2) : i_reg;
    assign rd_byte = (rd_idx < IW'(len_reg)) ? buf_reg[rd_idx[AW-1:0]] : 8'd0;
    assign hb0     = (len_reg != '0) ? head_reg[0] : 8'd0;
    assign hb1     = (len_reg > AW'(1)) ? head_reg[1] : 8'd0;
    assign hb2     = (len_reg > AW'(2)) ? head_reg[2] : 8'd0;
    assign dig      = {28'd0, 4'(rd_byte - CH_ZERO)};
    // raw byte minus '0', wrapping for bytes below '0'
    assign byte_off = {24'd0, rd_byte} - 32'd48;
    assign chk      = {hex_val(hb1), hex_val(hb2)};
    assign is_delim = (s_char_in == CH_COMMA) || (s_char_in == CH_STAR) ||
                      (s_char_in == CH_NL);
    assign res      = (act_cls(act_reg) == CLS_DEC && neg_reg) ? 32'd0 - acc_reg : acc_reg;
    assign abs_mn   = mn_reg[31] ? 32'd0 - mn_reg : mn_reg;
    assign q32      = {2'b00, prod_reg[63:34]};
    assign trial    = {rem_reg, dvd_reg[22]};
    assign qbit     = trial >= {1'b0, vis_reg};
    assign out_free = !m_valid_reg || m_ready;
    assign emit_load = (cmd.op == OP_EMIT) && out_free;
    assign eid      = emit_id(type_reg, slot_reg);

    always_comb begin
        unique case (eid)
            QID_TIME:       evalue = {time_reg[31], time_reg};
            QID_DATE:       evalue = {date_reg[31], date_reg};
            QID_LAT:        evalue = {lat_reg[31], lat_reg};
            QID_LON:        evalue = {lon_reg[31], lon_reg};
            QID_ALT:        evalue = {alt_reg[31], alt_reg};
            QID_SPEED:      evalue = {speed_reg[31], speed_reg};
            QID_COURSE:     evalue = {course_reg[31], course_reg};
            QID_HDOP:       evalue = {{17{hdop_reg[15]}}, hdop_reg};
            QID_PDOP:       evalue = {{17{pdop_reg[15]}}, pdop_reg};
            QID_VDOP:       evalue = {{17{vdop_reg[15]}}, vdop_reg};
            QID_FIXQ:       evalue = {29'd0, fixq_reg};
            QID_FIXTYPE:    evalue = {29'd0, fixtype_reg};
            QID_SATS:       evalue = {25'd0, sats_reg};
            QID_VISIBLE:    evalue = {25'd0, vis_reg};
            QID_SNR_AVG:    evalue = (vis_reg == 8'd0) ? 33'd0 : {10'd0, dvd_reg};
            QID_TIME_STAMP: evalue = {1'b0, tstamp_reg};
            QID_POS_STAMP:  evalue = {1'b0, pstamp_reg};
            default:        evalue = 33'd0;
        endcase
    end

    always_comb begin
        stat.is_delim   = is_delim;
        stat.cls        = act_cls(act_reg);
        stat.digit      = is_digit(rd_byte);
        stat.dot        = rd_byte == CH_DOT;
        stat.deg_go     = !look_dot_reg && is_digit(rd_byte);
        stat.cnt_more   = i_reg < IW'(len_reg);
        stat.star_match = star_reg && (chk == parity_reg);
        stat.sent_valid = (type_reg == KIND_GGA && fixq_reg != 4'd0) ||
                          (type_reg == KIND_GSA && fixtype_reg > 4'd1) ||
                          (type_reg == KIND_RMC && status_reg) ||
                          (type_reg == KIND_GSV && gidx_reg == gtot_reg);
        stat.is_gsv     = type_reg == KIND_GSV;
        stat.div_done   = dcnt_reg == 5'(DIV_STEPS);
        stat.out_free   = out_free;
        stat.emit_last  = slot_reg == run_len(type_reg) - 4'd1;
    end

    // term buffer: storage only, reads are gated by the length
    always_ff @(posedge aclk) begin
        if (in_acc && !is_delim && s_char_in != CH_DOLLAR &&
            len_reg != AW'(TERM_SIZE - 1)) begin
            buf_reg[len_reg] <= s_char_in;
            if (len_reg < AW'(5)) head_reg[3'(len_reg)] <= s_char_in;
        end else if (cmd.op == OP_TAIL && char_reg != CH_COMMA) begin
            buf_reg[0]  <= char_reg;
            head_reg[0] <= char_reg;
        end
    end

    // parse scratch registers
    always_ff @(posedge aclk) begin
        if (in_acc && is_delim) begin
            char_reg <= s_char_in;
            now_reg  <= s_now_ms;
            act_reg  <= classify(type_reg, k_reg);
            star_reg <= hb0 == CH_STAR;
        end
        case (cmd.op)
            OP_DEC_START: begin
                neg_reg <= hb0 == CH_MINUS;
                i_reg   <= (hb0 == CH_MINUS) ? IW'(1) : IW'(0);
                acc_reg <= 32'd0;
            end
            OP_DEC_INT: begin
                if (is_digit(rd_byte)) begin
                    acc_reg <= acc_reg * 32'd10 + dig;
                    i_reg   <= i_reg + IW'(1);
                end else begin
                    acc_reg <= acc_reg * 32'd100;
                end
            end
            OP_DEC_DOT: if (rd_byte == CH_DOT) i_reg <= i_reg + IW'(1);
            OP_DEC_F1: begin
                if (is_digit(rd_byte)) begin
                    acc_reg <= acc_reg + dig * 32'd10;
                    i_reg   <= i_reg + IW'(1);
                end
            end
            OP_DEC_F2:    if (is_digit(rd_byte)) acc_reg <= acc_reg + dig;
            OP_DEG_START: begin
                i_reg   <= '0;
                acc_reg <= 32'd0;
            end
            OP_DEG_LOOK:  look_dot_reg <= rd_byte == CH_DOT;
            OP_DEG_INT: begin
                if (!look_dot_reg && is_digit(rd_byte)) begin
                    acc_reg <= acc_reg * 32'd10 + dig;
                    i_reg   <= i_reg + IW'(1);
                end
            end
            OP_DEG_SCALE: acc_reg <= acc_reg * 32'd100000;
            OP_DEG_M1: begin
                mn_reg <= byte_off * 32'd10;
                i_reg  <= i_reg + IW'(1);
            end
            OP_DEG_M2: begin
                mn_reg <= mn_reg + byte_off;
                i_reg  <= i_reg + IW'(2);
            end
            OP_DEG_MLOOP: begin
                if (is_digit(rd_byte)) begin
                    mn_reg <= mn_reg * 32'd10 + dig;
                    i_reg  <= i_reg + IW'(1);
                end
            end
            OP_DEG_MUL: begin
                // minutes / 6 by reciprocal multiply, exact for 32-bit magnitudes
                neg_reg  <= mn_reg[31];
                prod_reg <= 64'(abs_mn) * 64'(RECIP_SIX);
            end
            OP_DEG_FIN:   acc_reg <= acc_reg + (neg_reg ? 32'd0 - q32 : q32);
            OP_CNT_START: begin
                i_reg   <= '0;
                acc_reg <= 32'd0;
            end
            OP_CNT_STEP: begin
                acc_reg <= acc_reg * 32'd10 + byte_off;
                i_reg   <= i_reg + IW'(1);
            end
            OP_DIV_START: begin
                dvd_reg  <= 23'(snr_reg) * 23'd100;
                rem_reg  <= 8'd0;
                dcnt_reg <= 5'd0;
            end
            OP_DIV_STEP: begin
                rem_reg  <= qbit ? 8'(trial - {1'b0, vis_reg}) : trial[7:0];
                dvd_reg  <= {dvd_reg[21:0], qbit};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            default: ;
        endcase
    end

    // sentence state and pending quantities
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            k_reg       <= 8'd0;
            type_reg    <= KIND_NONE;
            parity_reg  <= 8'd0;
            inchk_reg   <= 1'b0;
            status_reg  <= 1'b0;
            time_reg    <= INV_TIME;
            date_reg    <= 32'd0;
            lat_reg     <= INV_ANGLE;
            lon_reg     <= INV_ANGLE;
            alt_reg     <= INV_ANGLE;
            speed_reg   <= INV_TIME;
            course_reg  <= INV_ANGLE;
            hdop_reg    <= INV_DOP;
            pdop_reg    <= INV_DOP;
            vdop_reg    <= INV_DOP;
            fixq_reg    <= 4'd0;
            fixtype_reg <= 4'd0;
            sats_reg    <= INV_SATS;
            vis_reg     <= 8'd0;
            gtot_reg    <= 8'd0;
            gidx_reg    <= 8'd0;
            snr_reg     <= 16'd0;
            tstamp_reg  <= INV_TIME;
            pstamp_reg  <= INV_TIME;
            slot_reg    <= 4'd0;
        end else begin
            if (in_acc) begin
                if (s_char_in == CH_DOLLAR) begin
                    k_reg      <= 8'd0;
                    parity_reg <= 8'd0;
                    inchk_reg  <= 1'b0;
                    status_reg <= 1'b0;
                    type_reg   <= KIND_NONE;
                    len_reg    <= '0;
                end else if (is_delim) begin
                    inchk_reg <= s_char_in == CH_STAR;
                end else begin
                    if (len_reg != AW'(TERM_SIZE - 1)) len_reg <= len_reg + AW'(1);
                    if (!inchk_reg) parity_reg <= parity_reg ^ s_char_in;
                end
            end
            case (cmd.op)
                OP_IMM: begin
                    unique case (act_reg)
                        ACT_TYPE: begin
                            if (len_reg != AW'(5)) type_reg <= KIND_NONE;
                            else begin
                                unique case ({head_reg[0], head_reg[1], head_reg[2],
                                              head_reg[3], head_reg[4]})
                                    TAG_GGA: type_reg <= KIND_GGA;
                                    TAG_GSA: type_reg <= KIND_GSA;
                                    TAG_RMC: type_reg <= KIND_RMC;
                                    TAG_GSV: type_reg <= KIND_GSV;
                                    default: type_reg <= KIND_NONE;
                                endcase
                            end
                        end
                        ACT_LAT_SIGN: if (hb0 == CH_S) lat_reg <= 32'd0 - lat_reg;
                        ACT_LON_SIGN: if (hb0 == CH_W) lon_reg <= 32'd0 - lon_reg;
                        ACT_FIXQ:     fixq_reg <= hex_val(hb0);
                        ACT_FIXTYPE:  fixtype_reg <= is_digit(hb0) ? 4'(hb0 - CH_ZERO) : 4'd0;
                        ACT_STATUS:   status_reg <= hb0 == CH_A;
                        default: ;
                    endcase
                end
                OP_COMMIT: begin
                    unique case (act_reg)
                        ACT_TIME: begin
                            time_reg   <= res;
                            tstamp_reg <= now_reg;
                        end
                        ACT_LAT: begin
                            lat_reg    <= res;
                            pstamp_reg <= now_reg;
                        end
                        ACT_LON:    lon_reg    <= res;
                        ACT_ALT:    alt_reg    <= res;
                        ACT_SPEED:  speed_reg  <= res;
                        ACT_COURSE: course_reg <= res;
                        ACT_DATE:   date_reg   <= res;
                        ACT_HDOP:   hdop_reg   <= res[15:0];
                        ACT_PDOP:   pdop_reg   <= res[15:0];
                        ACT_VDOP:   vdop_reg   <= res[15:0];
                        ACT_SATS:   sats_reg   <= res[7:0];
                        ACT_GTOT:   gtot_reg   <= res[7:0];
                        ACT_GIDX:   gidx_reg   <= res[7:0];
                        ACT_VIS:    vis_reg    <= res[7:0];
                        ACT_SNR:    snr_reg    <= snr_reg + res[15:0];
                        default: ;
                    endcase
                end
                OP_TERM_END: begin
                    k_reg    <= k_reg + 8'd1;
                    slot_reg <= 4'd0;
                    if (star_reg) begin
                        inchk_reg <= 1'b1;
                        len_reg   <= '0;
                    end
                end
                OP_TAIL: begin
                    // the delimiter itself opens the next term unless it is a comma
                    len_reg <= (char_reg != CH_COMMA) ? AW'(1) : AW'(0);
                    if (!inchk_reg) parity_reg <= parity_reg ^ char_reg;
                end
                OP_EMIT:      if (out_free) slot_reg <= slot_reg + 4'd1;
                OP_GSV_CLEAR: begin
                    vis_reg <= 8'd0;
                    snr_reg <= 16'd0;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_kind_reg  <= type_reg[1:0];
            m_id_reg    <= eid;
            m_value_reg <= evalue;
            m_last_reg  <= slot_reg == run_len(type_reg) - 4'd1;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sentence_kind  = m_kind_reg;
    assign m_quantity_id    = m_id_reg;
    assign m_quantity_value = m_value_reg;
    assign m_last_of_run    = m_last_reg;

endmodule

### src/nmea_sentence_decoder_unit.sv
// NMEA sentence decoder: accepts one byte per request and emits runs of quantity results.
// A byte that is not a comma, star or newline is taken in the idle state. A delimiter ends
// a term and blocks input while the sequencer parses the term from the buffer: a decimal
// by its integer digits, dot and up to two fraction digits, an angle by its degree digits
// and then its minutes, a count by its digits. A sentence that passes its checksum and its
// validity test then sends one result per cycle while the output is taken; a final GSV
// first runs the SNR divide.
// The last result of a run may still wait in the output register while new bytes are taken.
module nmea_sentence_decoder_unit
    import nsd_pkg::*;
#(
    parameter int TERM_SIZE = 16
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_sentence_kind,
    output logic [4:0]         m_quantity_id,
    output logic signed [32:0] m_quantity_value,
    output logic               m_last_of_run
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_acc;

    assign in_acc = s_valid && s_ready;

    nsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (in_acc),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    nsd_datapath #(
        .TERM_SIZE (TERM_SIZE)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_acc           (in_acc),
        .s_char_in        (s_char_in),
        .s_now_ms         (s_now_ms),
        .cmd              (cmd),
        .stat             (stat),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_sentence_kind  (m_sentence_kind),
        .m_quantity_id    (m_quantity_id),
        .m_quantity_value (m_quantity_value),
        .m_last_of_run    (m_last_of_run)
    );

    // the final result of every run is one of the three closing quantities
    a_last_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_run) |->
            (m_quantity_id == QID_POS_STAMP || m_quantity_id == QID_FIXTYPE ||
             m_quantity_id == QID_SNR_AVG))
        else $error("run closed on unexpected quantity");

    a_gsv_ids: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sentence_kind == 2'(KIND_GSV)) |->
            (m_quantity_id == QID_VISIBLE || m_quantity_id == QID_SNR_AVG))
        else $error("GSV request carries a foreign quantity");

    // no new byte is taken while a run is still being loaded
    a_busy_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !m_last_of_run) |-> !s_ready)
        else $error("input taken in the middle of a result run");

endmodule
